// ===== rtl/breathing_led_pwm_assert.svh =====
// Assertion macros used by the breathing LED PWM RTL (blp_core).
`ifndef BREATHING_LED_PWM_ASSERT_SVH
`define BREATHING_LED_PWM_ASSERT_SVH

// Check that an expression holds at every clock edge outside reset.
`define BLP_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");

// Check that a condition implies a consequence on the following edge.
`define BLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: sequence violated");

`endif

// ===== rtl/blp_pkg.sv =====
// Package with shared types and constants of the breathing LED PWM block.
`default_nettype none
package blp_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned KEYS_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_ONE   = 2'd0,
    REG_PERIOD_TWO   = 2'd1,
    REG_PERIOD_THREE = 2'd2,
    REG_PERIOD_FOUR  = 2'd3
  } cfg_reg_t;

  localparam logic [KEYS_W-1:0] KEY_ONE   = 4'b0001;
  localparam logic [KEYS_W-1:0] KEY_TWO   = 4'b0010;
  localparam logic [KEYS_W-1:0] KEY_THREE = 4'b0100;
  localparam logic [KEYS_W-1:0] KEY_FOUR  = 4'b1000;

  localparam logic [CODE_W-1:0] SEG_KEY_ONE   = 8'h5b;
  localparam logic [CODE_W-1:0] SEG_KEY_TWO   = 8'h06;
  localparam logic [CODE_W-1:0] SEG_KEY_THREE = 8'h4f;
  localparam logic [CODE_W-1:0] SEG_KEY_FOUR  = 8'h66;
  localparam logic [CODE_W-1:0] SEG_BLANK     = 8'hff;

  localparam logic [PERIOD_W-1:0] PERIOD_ONE_RST   = 16'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_TWO_RST   = 16'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_THREE_RST = 16'd200;
  localparam logic [PERIOD_W-1:0] PERIOD_FOUR_RST  = 16'd300;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [CODE_W-1:0]   code;
  } speed_t;

endpackage
`default_nettype wire

// ===== rtl/blp_speed.sv =====
// Key period registers and speed selection with the latched segment code.
`default_nettype none
module blp_speed (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::PERIOD_W-1:0]   cfg_data,
  input  wire logic                           accept,
  input  wire logic [blp_pkg::KEYS_W-1:0]     keys_pressed,
  output blp_pkg::speed_t                     sel
);

  logic [blp_pkg::PERIOD_W-1:0] period_key [4];
  logic [blp_pkg::PERIOD_W-1:0] step_period;
  logic [blp_pkg::CODE_W-1:0]   shown_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_key[0] <= blp_pkg::PERIOD_ONE_RST;
      period_key[1] <= blp_pkg::PERIOD_TWO_RST;
      period_key[2] <= blp_pkg::PERIOD_THREE_RST;
      period_key[3] <= blp_pkg::PERIOD_FOUR_RST;
    end else if (cfg_we) begin
      unique case (blp_pkg::cfg_reg_t'(cfg_index))
        blp_pkg::REG_PERIOD_ONE:   period_key[0] <= cfg_data;
        blp_pkg::REG_PERIOD_TWO:   period_key[1] <= cfg_data;
        blp_pkg::REG_PERIOD_THREE: period_key[2] <= cfg_data;
        blp_pkg::REG_PERIOD_FOUR:  period_key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Exactly one key pressed picks a new speed; anything else holds.
  always_comb begin
    sel.period = step_period;
    sel.code   = shown_code;
    unique case (keys_pressed)
      blp_pkg::KEY_ONE: begin
        sel.period = period_key[0];
        sel.code   = blp_pkg::SEG_KEY_ONE;
      end
      blp_pkg::KEY_TWO: begin
        sel.period = period_key[1];
        sel.code   = blp_pkg::SEG_KEY_TWO;
      end
      blp_pkg::KEY_THREE: begin
        sel.period = period_key[2];
        sel.code   = blp_pkg::SEG_KEY_THREE;
      end
      blp_pkg::KEY_FOUR: begin
        sel.period = period_key[3];
        sel.code   = blp_pkg::SEG_KEY_FOUR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= blp_pkg::PERIOD_ONE_RST;
      shown_code  <= blp_pkg::SEG_BLANK;
    end else if (accept) begin
      step_period <= sel.period;
      shown_code  <= sel.code;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/blp_core.sv =====
// Step, phase and brightness counters with the triangle direction flag.
`default_nettype none
`include "breathing_led_pwm_assert.svh"
module blp_core #(
  parameter int unsigned TOP_LEVEL = 1000,
  localparam int unsigned LW = $clog2(TOP_LEVEL + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  blp_pkg::speed_t      sel,
  output logic [LW-1:0]        level_next,
  output logic                 pwm_next
);

  localparam logic [LW-1:0] TOP_L = LW'(TOP_LEVEL);
  localparam logic [LW:0]   TOP_X = (LW + 1)'(TOP_LEVEL);

  logic [blp_pkg::PERIOD_W-1:0] tick_count;
  logic [blp_pkg::PERIOD_W-1:0] tick_count_next;
  logic [blp_pkg::PERIOD_W-1:0] tick_inc;
  logic [LW-1:0]                phase_count;
  logic [LW-1:0]                phase_count_next;
  logic [LW:0]                  phase_inc;
  logic [LW-1:0]                level;
  logic                         rising;
  logic                         rising_next;
  logic                         step;

  always_comb begin
    tick_inc        = tick_count + 1'b1;
    step            = tick_inc > sel.period;
    tick_count_next = step ? '0 : tick_inc;

    // On a step, move one level in the current direction, holding at the ends.
    level_next = level;
    if (step) begin
      if (rising) begin
        if (level < TOP_L) level_next = level + 1'b1;
      end else begin
        if (level != '0) level_next = level - 1'b1;
      end
    end

    rising_next = rising;
    if (level_next >= TOP_L) rising_next = 1'b0;
    if (level_next == '0)    rising_next = 1'b1;

    phase_inc        = {1'b0, phase_count} + 1'b1;
    phase_count_next = (phase_inc > TOP_X) ? '0 : phase_inc[LW-1:0];

    pwm_next = phase_count_next < level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      phase_count <= '0;
      level       <= '0;
      rising      <= 1'b1;
    end else if (accept) begin
      tick_count  <= tick_count_next;
      phase_count <= phase_count_next;
      level       <= level_next;
      rising      <= rising_next;
    end
  end

  `BLP_ASSERT_ALWAYS(a_level_range, clk, rst, level <= TOP_L)
  `BLP_ASSERT_ALWAYS(a_phase_range, clk, rst, phase_count <= TOP_L)
  `BLP_ASSERT_ALWAYS(a_dir_at_ends, clk, rst,
    (level != '0 || rising) && (level != TOP_L || !rising))
  `BLP_ASSERT_NEXT(a_hold_idle, clk, rst, !accept, $stable(level) && $stable(tick_count))
  `BLP_ASSERT_NEXT(a_one_step, clk, rst, accept,
    (level == $past(level)) || ({1'b0, level} == {1'b0, $past(level)} + 1'b1) ||
    ({1'b0, $past(level)} == {1'b0, level} + 1'b1))

endmodule
`default_nettype wire

// ===== rtl/breathing_led_pwm.sv =====
// An accepted key beat's result is registered and shown in the next cycle.
// Throughput: one tick per cycle while the receiver keeps res_ready high; a new
// beat is taken while the result register drains, behind a single output register stage.
// Reset: synchronous, active high; periods return to 100/50/200/300, brightness
// level to zero counting up, latched segment code to all ones.
`default_nettype none
module breathing_led_pwm #(
  parameter int unsigned TOP_LEVEL = 1000,
  localparam int unsigned LW = $clog2(TOP_LEVEL + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [blp_pkg::PERIOD_W-1:0]   cfg_data,
  input  wire logic                           key_valid,
  output logic                                key_ready,
  input  wire logic [blp_pkg::KEYS_W-1:0]     keys_pressed,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic                                pwm_out,
  output logic [blp_pkg::CODE_W-1:0]          segment_code,
  output logic [LW-1:0]                       brightness
);

  blp_pkg::speed_t sel;
  logic            accept;
  logic [LW-1:0]   level_next;
  logic            pwm_next;

  // Take a beat outside reset whenever the result register is empty or draining.
  assign key_ready = !rst && (!res_valid || res_ready);
  assign accept    = key_valid && key_ready;

  blp_speed u_speed (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .keys_pressed (keys_pressed),
    .sel          (sel)
  );

  blp_core #(
    .TOP_LEVEL (TOP_LEVEL)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sel        (sel),
    .level_next (level_next),
    .pwm_next   (pwm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pwm_out      <= pwm_next;
      segment_code <= sel.code;
      brightness   <= level_next;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_breathing_led_pwm.sv =====
// Self-checking testbench for the breathing LED PWM block.
`timescale 1ns / 100ps

module tb_breathing_led_pwm;

  localparam int unsigned TOP_LEVEL = 1000;

  typedef logic [blp_pkg::KEYS_W-1:0]   keys_t;
  typedef logic [blp_pkg::PERIOD_W-1:0] period_t;

  typedef struct packed {
    logic       pwm;
    logic [7:0] seg;
    logic [9:0] bright;
  } led_result_t;

  class led_scoreboard;
    logic [blp_pkg::PERIOD_W-1:0] period_reg [4];
    logic [blp_pkg::PERIOD_W-1:0] step_period;
    logic [blp_pkg::CODE_W-1:0]   shown_code;
    logic [15:0]                  tick_count;
    logic [9:0]                   phase_count;
    logic [9:0]                   level;
    logic                         rising;
    led_result_t                  pending [$];
    int                           errors;
    int                           ticks;
    int                           peak;
    int                           turns;

    function void reset_state();
      period_reg[blp_pkg::REG_PERIOD_ONE]   = blp_pkg::PERIOD_ONE_RST;
      period_reg[blp_pkg::REG_PERIOD_TWO]   = blp_pkg::PERIOD_TWO_RST;
      period_reg[blp_pkg::REG_PERIOD_THREE] = blp_pkg::PERIOD_THREE_RST;
      period_reg[blp_pkg::REG_PERIOD_FOUR]  = blp_pkg::PERIOD_FOUR_RST;
      step_period = blp_pkg::PERIOD_ONE_RST;
      shown_code  = blp_pkg::SEG_BLANK;
      tick_count  = '0;
      phase_count = '0;
      level       = '0;
      rising      = 1'b1;
      errors      = 0;
      ticks       = 0;
      peak        = 0;
      turns       = 0;
    endfunction

    function void write_period(blp_pkg::cfg_reg_t idx, logic [blp_pkg::PERIOD_W-1:0] value);
      period_reg[idx] = value;
    endfunction

    // Advance the LED state by one tick and queue the result it produces.
    function void note_tick(logic [blp_pkg::KEYS_W-1:0] keys);
      led_result_t r;
      case (keys)
        blp_pkg::KEY_ONE: begin
          step_period = period_reg[blp_pkg::REG_PERIOD_ONE];
          shown_code  = blp_pkg::SEG_KEY_ONE;
        end
        blp_pkg::KEY_TWO: begin
          step_period = period_reg[blp_pkg::REG_PERIOD_TWO];
          shown_code  = blp_pkg::SEG_KEY_TWO;
        end
        blp_pkg::KEY_THREE: begin
          step_period = period_reg[blp_pkg::REG_PERIOD_THREE];
          shown_code  = blp_pkg::SEG_KEY_THREE;
        end
        blp_pkg::KEY_FOUR: begin
          step_period = period_reg[blp_pkg::REG_PERIOD_FOUR];
          shown_code  = blp_pkg::SEG_KEY_FOUR;
        end
        default: ;
      endcase
      phase_count = phase_count + 10'd1;
      tick_count  = tick_count + 16'd1;
      if (tick_count > step_period) begin
        tick_count = '0;
        if (rising) begin
          if (level < TOP_LEVEL) level = level + 10'd1;
        end else if (level > 0) begin
          level = level - 10'd1;
        end
      end
      // turn around at either end of the triangle
      if (level >= TOP_LEVEL && rising) begin
        rising = 1'b0;
        turns++;
      end
      if (level == 0 && !rising) begin
        rising = 1'b1;
        turns++;
      end
      if (phase_count > TOP_LEVEL) phase_count = '0;
      r.pwm    = (phase_count < level);
      r.seg    = shown_code;
      r.bright = level;
      pending.push_back(r);
      ticks++;
      if (level > peak) peak = level;
    endfunction

    function void check_result(logic pwm, logic [7:0] seg, logic [9:0] bright);
      led_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected: pwm %0d seg %h brightness %0d",
                 $time, pwm, seg, bright);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pwm !== e.pwm) begin
        $display("%0t: pwm_out expected %0d, actual %0d", $time, e.pwm, pwm);
        errors++;
      end
      if (seg !== e.seg) begin
        $display("%0t: segment_code expected %h, actual %h", $time, e.seg, seg);
        errors++;
      end
      if (bright !== e.bright) begin
        $display("%0t: brightness expected %0d, actual %0d", $time, e.bright, bright);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [blp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [blp_pkg::PERIOD_W-1:0]  cfg_data;
  logic                          key_valid;
  logic                          key_ready;
  logic [blp_pkg::KEYS_W-1:0]    keys_pressed;
  logic                          res_valid;
  logic                          res_ready;
  logic                          pwm_out;
  logic [blp_pkg::CODE_W-1:0]    segment_code;
  logic [9:0]                    brightness;

  led_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int settings_used;

  logic [blp_pkg::KEYS_W-1:0] opening_keys [21] = '{
    4'b0000, blp_pkg::KEY_ONE, blp_pkg::KEY_TWO, blp_pkg::KEY_THREE, blp_pkg::KEY_FOUR,
    4'b0011, 4'b1111, 4'b0101, 4'b1010, blp_pkg::KEY_TWO, 4'b0110, 4'b1001,
    blp_pkg::KEY_FOUR, 4'b1100, 4'b0111, 4'b1110, 4'b0000, blp_pkg::KEY_THREE,
    4'b1011, 4'b1101, blp_pkg::KEY_ONE
  };

  breathing_led_pwm #(
    .TOP_LEVEL(TOP_LEVEL)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .key_valid   (key_valid),
    .key_ready   (key_ready),
    .keys_pressed(keys_pressed),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .pwm_out     (pwm_out),
    .segment_code(segment_code),
    .brightness  (brightness)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each beat, then pick next ready (long hold-off first).
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result(pwm_out, segment_code, brightness);
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [blp_pkg::KEYS_W-1:0] pick_keys();
    case ($urandom_range(9))
      0, 1:    return blp_pkg::KEY_ONE;
      2, 3:    return blp_pkg::KEY_TWO;
      4, 5:    return blp_pkg::KEY_THREE;
      6, 7:    return blp_pkg::KEY_FOUR;
      default: return keys_t'($urandom_range(15));
    endcase
  endfunction

  // Offer one tick beat and wait for it to be taken.
  task automatic offer_tick(input logic [blp_pkg::KEYS_W-1:0] k);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid    <= 1'b1;
    keys_pressed <= k;
    do @(posedge clk); while (!key_ready);
    sb.note_tick(k);
  endtask

  task automatic run_ticks(input int count);
    for (int i = 0; i < count; i++) offer_tick(pick_keys());
    key_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input blp_pkg::cfg_reg_t idx,
                              input logic [blp_pkg::PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_period(idx, value);
  endtask

  task automatic load_periods(input logic [blp_pkg::PERIOD_W-1:0] p1, p2, p3, p4);
    wait_drained();
    write_period(blp_pkg::REG_PERIOD_ONE, p1);
    write_period(blp_pkg::REG_PERIOD_TWO, p2);
    write_period(blp_pkg::REG_PERIOD_THREE, p3);
    write_period(blp_pkg::REG_PERIOD_FOUR, p4);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    settings_used  = 1;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= blp_pkg::REG_PERIOD_ONE;
    cfg_data     <= '0;
    key_valid    <= 1'b0;
    keys_pressed <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset periods, every key mask shape
    foreach (opening_keys[i]) offer_tick(opening_keys[i]);
    key_valid <= 1'b0;

    // fast periods so the level steps on most ticks and climbs quickly
    load_periods(16'd0, 16'd1, 16'd0, 16'd2);
    run_ticks(300);

    load_periods(16'd0, 16'd0, 16'hffff, 16'd0);
    send_idle_pct = 73;
    run_ticks(300);

    load_periods(16'd1, 16'd0, 16'd0, 16'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    hold_left      = 80;
    run_ticks(300);

    load_periods(16'd0, 16'd0, 16'd0, 16'd0);
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_ticks(500);

    // largest periods: the level holds
    load_periods(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_ticks(100);

    load_periods(period_t'($urandom_range(15)), period_t'($urandom_range(15)),
                 period_t'($urandom_range(15)), period_t'($urandom_range(300)));
    recv_stall_pct = 27;
    run_ticks(100);

    wait_drained();
    $display("Ran %0d ticks over %0d period settings, with idle senders, stalled and",
             sb.ticks, settings_used);
    $display("held-off receivers; brightness peaked at %0d and turned %0d times.",
             sb.peak, sb.turns);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout waiting for the block to drain");
    $display("Some tests failed");
    $finish;
  end

endmodule
